// ===== src/sbsi_pkg.sv =====
// Shared types, constants and helpers for the segment/box slab intersection block.
// No dependencies; every other file refers to it by scoped names.
package sbsi_pkg;

	localparam int NUM_CELLS = 33;  // one quotient bit per divider cell
	localparam int NUM_LANES = 6;   // min and max slab distance on three axes
	localparam logic signed [33:0] T_NEG_INF = -34'sd4294967296;
	localparam logic signed [33:0] T_POS_INF = 34'sd4294967296;
	localparam logic signed [33:0] T_ONE     = 34'sd65536;
	localparam logic signed [31:0] S32_MAX   = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN   = 32'sh80000000;

	typedef struct packed {
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
		logic signed [31:0] seg_origin_x;
		logic signed [31:0] seg_origin_y;
		logic signed [31:0] seg_origin_z;
		logic signed [31:0] seg_dir_x;
		logic signed [31:0] seg_dir_y;
		logic signed [31:0] seg_dir_z;
	} query_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] contact_x;
		logic signed [31:0] contact_y;
		logic signed [31:0] contact_z;
	} result_t;

	// One divider lane: |distance| * 65536 / |dir|, quotient bits shift into nq
	typedef struct packed {
		logic [31:0] dmag;
		logic [31:0] rem;
		logic [32:0] nq;
		logic        neg;
		logic        ovf;
	} lane_t;

	// Everything a divider cell hands to its neighbor
	typedef struct packed {
		lane_t [NUM_LANES-1:0]    lane;
		logic signed [2:0][31:0]  org;
		logic signed [2:0][31:0]  dir;
		logic                     zmiss;
	} cell_t;

	// Saturate a sign/magnitude quotient to signed 32 bits
	function automatic logic signed [31:0] sat_quot(input logic [32:0] q, input logic ovf,
			input logic neg);
		logic [32:0] nq;
		nq = -q;
		if (!neg) begin
			sat_quot = (ovf || q[32:31] != 2'b00) ? S32_MAX : q[31:0];
		end else begin
			sat_quot = (ovf || q > 33'h080000000) ? S32_MIN : nq[31:0];
		end
	endfunction

endpackage

// ===== src/sbsi_prep.sv =====
// Front stage: slab distances, magnitudes and signs, zero-direction miss check.
// Depends on sbsi_pkg.
module sbsi_prep (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  sbsi_pkg::query_t   query,
	output logic               out_valid,
	output sbsi_pkg::cell_t    out_cell
);

	logic signed [2:0][31:0] bmin, bmax, org, dir;
	sbsi_pkg::cell_t cell_d;
	logic valid_s1;
	sbsi_pkg::cell_t cell_s1;

	assign bmin = {query.box_min_z, query.box_min_y, query.box_min_x};
	assign bmax = {query.box_max_z, query.box_max_y, query.box_max_x};
	assign org  = {query.seg_origin_z, query.seg_origin_y, query.seg_origin_x};
	assign dir  = {query.seg_dir_z, query.seg_dir_y, query.seg_dir_x};

	always_comb begin
		logic signed [32:0] diff;
		logic [32:0] mag;
		logic [31:0] dmag;
		logic [31:0] ndir;
		cell_d = '0;
		cell_d.org = org;
		cell_d.dir = dir;
		for (int a = 0; a < 3; a++) begin
			ndir = -dir[a];
			dmag = dir[a][31] ? ndir : dir[a];
			if (dir[a] == 32'sd0 && ($signed(org[a]) < $signed(bmin[a]) ||
			                         $signed(org[a]) > $signed(bmax[a])))
				cell_d.zmiss = 1'b1;
			for (int s = 0; s < 2; s++) begin
				diff = (s == 0) ? ({bmin[a][31], bmin[a]} - {org[a][31], org[a]})
				                : ({bmax[a][31], bmax[a]} - {org[a][31], org[a]});
				mag  = diff[32] ? -diff : diff;
				cell_d.lane[2*a+s].dmag = dmag;
				cell_d.lane[2*a+s].rem  = {15'd0, mag[32:16]} >> 1;
				cell_d.lane[2*a+s].nq   = {mag[16:0], 16'd0};
				cell_d.lane[2*a+s].neg  = diff[32] ^ dir[a][31];
				// quotient needs more than 33 bits
				cell_d.lane[2*a+s].ovf  = ({16'd0, mag[32:17]} >= dmag);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cell_s1 <= cell_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_cell  = cell_s1;

endmodule

// ===== src/sbsi_div_cell.sv =====
// One divider cell: produces one quotient bit on all six lanes per cycle while adv is high.
// Depends on sbsi_pkg.
module sbsi_div_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             prv_valid,
	input  sbsi_pkg::cell_t  prv,
	output logic             nxt_valid,
	output sbsi_pkg::cell_t  nxt
);

	sbsi_pkg::cell_t cell_d;
	logic valid_q;
	sbsi_pkg::cell_t cell_q;

	always_comb begin
		logic [32:0] r2;
		logic [32:0] diff;
		logic ge;
		cell_d = prv;
		for (int l = 0; l < sbsi_pkg::NUM_LANES; l++) begin
			r2   = {prv.lane[l].rem, prv.lane[l].nq[32]};
			ge   = (r2 >= {1'b0, prv.lane[l].dmag});
			diff = r2 - {1'b0, prv.lane[l].dmag};
			cell_d.lane[l].rem = ge ? diff[31:0] : r2[31:0];
			cell_d.lane[l].nq  = {prv.lane[l].nq[31:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= prv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cell_q <= cell_d;
		end
	end

	assign nxt_valid = valid_q;
	assign nxt       = cell_q;

endmodule

// ===== src/sbsi_finish.sv =====
// Back end: saturate t, narrow entry/exit, decide hit, scale direction, add origin.
// Depends on sbsi_pkg.
module sbsi_finish (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_valid,
	input  sbsi_pkg::cell_t    cell_in,
	output logic               out_valid,
	output sbsi_pkg::result_t  result
);

	logic hit;
	logic [16:0] tc;
	logic valid_s1, valid_s2, valid_s3;
	logic hit_s1, hit_s2;
	logic [16:0] tc_s1;
	logic signed [2:0][31:0] org_s1, org_s2, dir_s1;
	logic signed [2:0][49:0] prod_s2;
	sbsi_pkg::result_t res, res_s3;

	always_comb begin
		logic signed [31:0] t1, t2;
		logic signed [33:0] lo, hi, entry, exit_t;
		entry  = sbsi_pkg::T_NEG_INF;
		exit_t = sbsi_pkg::T_POS_INF;
		for (int a = 0; a < 3; a++) begin
			t1 = sbsi_pkg::sat_quot(cell_in.lane[2*a].nq, cell_in.lane[2*a].ovf,
				cell_in.lane[2*a].neg);
			t2 = sbsi_pkg::sat_quot(cell_in.lane[2*a+1].nq, cell_in.lane[2*a+1].ovf,
				cell_in.lane[2*a+1].neg);
			lo = (t1 < t2) ? 34'(t1) : 34'(t2);
			hi = (t1 < t2) ? 34'(t2) : 34'(t1);
			if (cell_in.dir[a] != 32'sd0) begin
				if (lo > entry)  entry  = lo;
				if (hi < exit_t) exit_t = hi;
			end
		end
		hit = !cell_in.zmiss && entry <= exit_t && exit_t >= 34'sd0 &&
			entry <= sbsi_pkg::T_ONE;
		tc  = (hit && entry > 34'sd0) ? entry[16:0] : 17'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_s1 <= hit;
			tc_s1  <= tc;
			org_s1 <= cell_in.org;
			dir_s1 <= cell_in.dir;
			hit_s2 <= hit_s1;
			org_s2 <= org_s1;
			for (int a = 0; a < 3; a++)
				prod_s2[a] <= $signed({1'b0, tc_s1}) * $signed(dir_s1[a]);
			res_s3 <= res;
		end
	end

	always_comb begin
		logic signed [49:0] biased;
		logic signed [33:0] off, sum;
		logic signed [2:0][31:0] c;
		for (int a = 0; a < 3; a++) begin
			// truncate toward zero: bias negatives before the shift
			biased = prod_s2[a][49] ? (prod_s2[a] + 50'sd65535) : prod_s2[a];
			off    = 34'(biased >>> 16);
			sum    = 34'($signed(org_s2[a])) + off;
			if (sum > 34'(sbsi_pkg::S32_MAX))      c[a] = sbsi_pkg::S32_MAX;
			else if (sum < 34'(sbsi_pkg::S32_MIN)) c[a] = sbsi_pkg::S32_MIN;
			else                                   c[a] = sum[31:0];
			if (!hit_s2) c[a] = 32'sd0;
		end
		res.hit       = hit_s2;
		res.contact_x = c[0];
		res.contact_y = c[1];
		res.contact_z = c[2];
	end

	assign out_valid = valid_s3;
	assign result    = res_s3;

endmodule

// ===== src/segment_box_slab_intersect.sv =====
// Top level of the segment versus axis-aligned box slab test.
// Depends on sbsi_pkg, sbsi_prep, sbsi_div_cell, sbsi_finish.
//
//   channel  handshake                    payload
//   query    query_valid / query_ready    sbsi_pkg::query_t   (box and segment)
//   result   result_valid / result_ready  sbsi_pkg::result_t  (hit, contact point)
//
// One transaction per cycle unless result stalls; one front stage, 33 divider
// cells (one quotient bit each), three back-end stages ending in the output register.
// The whole pipeline advances together whenever the output register is empty or taken,
// so a stall on result holds every stage and drops query_ready.
// Reset clears all stage valid bits; no clearing pass is needed.
module segment_box_slab_intersect (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               query_valid,
	output logic               query_ready,
	input  sbsi_pkg::query_t   query,
	output logic               result_valid,
	input  logic               result_ready,
	output sbsi_pkg::result_t  result
);

	logic adv;
	logic            chain_valid [0:sbsi_pkg::NUM_CELLS];
	sbsi_pkg::cell_t chain       [0:sbsi_pkg::NUM_CELLS];

	// advance when the output register frees up this cycle
	assign adv         = !result_valid || result_ready;
	assign query_ready = adv;

	sbsi_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (query_valid),
		.query     (query),
		.out_valid (chain_valid[0]),
		.out_cell  (chain[0])
	);

	for (genvar i = 0; i < sbsi_pkg::NUM_CELLS; i++) begin : g_cell
		sbsi_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.prv_valid (chain_valid[i]),
			.prv       (chain[i]),
			.nxt_valid (chain_valid[i+1]),
			.nxt       (chain[i+1])
		);
	end

	sbsi_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (chain_valid[sbsi_pkg::NUM_CELLS]),
		.cell_in   (chain[sbsi_pkg::NUM_CELLS]),
		.out_valid (result_valid),
		.result    (result)
	);

endmodule
